// ===== src/sabp_pkg.sv =====
// Package for the stream anchor byte patcher: widths, register indexes, reset values and types.
package sabp_pkg;

    localparam int BYTE_W       = 8;
    localparam int ANCHOR_W     = 56;
    localparam int CFG_DATA_W   = 56;
    localparam int CFG_INDEX_W  = 3;
    localparam int MATCH_W      = 4;
    localparam int TAIL_POS_W   = 5;

    localparam logic [MATCH_W-1:0]    ANCHOR_LEN      = 4'd14;
    localparam logic [TAIL_POS_W-1:0] TAIL_FIRST_SITE = 5'd1;
    localparam logic [TAIL_POS_W-1:0] TAIL_LAST_SITE  = 5'd17;

    // Register indexes on the configuration channel.
    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ANCHOR_HEAD = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ANCHOR_TAIL = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MATCH_VALUE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_REPL  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SECOND_REPL = 3'd5;

    // Reset values of the registers.
    localparam logic [ANCHOR_W-1:0] ANCHOR_HEAD_RST = 56'h0001AE5B5E7500;
    localparam logic [ANCHOR_W-1:0] ANCHOR_TAIL_RST = 56'h6D000400010005;
    localparam logic [BYTE_W-1:0]   MATCH_VALUE_RST = 8'h05;
    localparam logic [BYTE_W-1:0]   FIRST_REPL_RST  = 8'h02;
    localparam logic [BYTE_W-1:0]   SECOND_REPL_RST = 8'h03;

    typedef struct packed {
        logic                enable;
        logic [ANCHOR_W-1:0] anchor_head;
        logic [ANCHOR_W-1:0] anchor_tail;
        logic [BYTE_W-1:0]   match_value;
        logic [BYTE_W-1:0]   first_replacement;
        logic [BYTE_W-1:0]   second_replacement;
    } sabp_cfg_t;

    typedef struct packed {
        logic [MATCH_W-1:0]    anchor_matched;
        logic                  tail_active;
        logic [TAIL_POS_W-1:0] tail_position;
    } sabp_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              rewrote;
        logic              rewrite_site;
    } sabp_result_t;

    // Anchor byte at position idx; byte 0 sits in the top bits of the head word.
    function automatic logic [BYTE_W-1:0] anchor_byte(
        input logic [ANCHOR_W-1:0] head,
        input logic [ANCHOR_W-1:0] tail,
        input logic [MATCH_W-1:0]  idx
    );
        logic [2*ANCHOR_W-1:0] full;
        logic [MATCH_W-1:0]    rev;
        logic [6:0]            base;
        full = {head, tail};
        rev  = (ANCHOR_LEN - 4'd1) - idx;
        base = {rev, 3'b000};
        if (idx < ANCHOR_LEN) begin
            return full[base +: BYTE_W];
        end
        return '0;
    endfunction

endpackage

// ===== src/sabp_if.sv =====
// Channel interfaces of the stream anchor byte patcher: byte stream, result stream, configuration.
interface sabp_stream_if
    import sabp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface sabp_result_if
    import sabp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              rewrote;
    logic              rewrite_site;

    modport source (output valid, output out_byte, output rewrote, output rewrite_site,
                    input ready);
    modport sink   (input valid, input out_byte, input rewrote, input rewrite_site,
                    output ready);
endinterface

interface sabp_cfg_if
    import sabp_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/sabp_cfg_regs.sv =====
// Configuration register file of the stream anchor byte patcher.
module sabp_cfg_regs
    import sabp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    sabp_cfg_if.sink        cfg,
    output sabp_cfg_t       cfg_q
);

    sabp_cfg_t cfg_reg;
    sabp_cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid) begin
            unique case (cfg.index)
                REG_ENABLE:      cfg_next.enable             = cfg.data[0];
                REG_ANCHOR_HEAD: cfg_next.anchor_head        = cfg.data[ANCHOR_W-1:0];
                REG_ANCHOR_TAIL: cfg_next.anchor_tail        = cfg.data[ANCHOR_W-1:0];
                REG_MATCH_VALUE: cfg_next.match_value        = cfg.data[BYTE_W-1:0];
                REG_FIRST_REPL:  cfg_next.first_replacement  = cfg.data[BYTE_W-1:0];
                REG_SECOND_REPL: cfg_next.second_replacement = cfg.data[BYTE_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.enable             <= 1'b0;
            cfg_reg.anchor_head        <= ANCHOR_HEAD_RST;
            cfg_reg.anchor_tail        <= ANCHOR_TAIL_RST;
            cfg_reg.match_value        <= MATCH_VALUE_RST;
            cfg_reg.first_replacement  <= FIRST_REPL_RST;
            cfg_reg.second_replacement <= SECOND_REPL_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== src/sabp_step.sv =====
// Anchor tracking state and the per-byte match and rewrite logic.
module sabp_step
    import sabp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [BYTE_W-1:0] data_byte,
    input  sabp_cfg_t         cfg_q,
    output sabp_result_t      result,
    output sabp_state_t       state_q
);

    sabp_state_t state_reg;
    sabp_state_t state_next;

    logic [MATCH_W-1:0] cur_idx;
    logic [MATCH_W-1:0] inc_idx;
    logic               byte_is_match;
    logic               hit_anchor;
    logic               hit_first;

    assign state_q       = state_reg;
    assign byte_is_match = (data_byte == cfg_q.match_value);
    assign cur_idx       = (state_reg.anchor_matched >= ANCHOR_LEN) ? '0
                                                                    : state_reg.anchor_matched;
    assign inc_idx       = cur_idx + 4'd1;
    assign hit_anchor    = (data_byte == anchor_byte(cfg_q.anchor_head, cfg_q.anchor_tail,
                                                     cur_idx));
    assign hit_first     = (data_byte == anchor_byte(cfg_q.anchor_head, cfg_q.anchor_tail,
                                                     '0));

    always_comb
    begin
        state_next          = state_reg;
        result.out_byte     = data_byte;
        result.rewrote      = 1'b0;
        result.rewrite_site = 1'b0;
        if (cfg_q.enable) begin
            if (state_reg.tail_active) begin
                if (state_reg.tail_position == TAIL_FIRST_SITE && byte_is_match) begin
                    result.out_byte = cfg_q.first_replacement;
                    result.rewrote  = 1'b1;
                end
                if (state_reg.tail_position >= TAIL_LAST_SITE) begin
                    if (byte_is_match) begin
                        result.out_byte     = cfg_q.second_replacement;
                        result.rewrote      = 1'b1;
                        result.rewrite_site = 1'b1;
                    end
                    state_next.tail_active    = 1'b0;
                    state_next.tail_position  = '0;
                    state_next.anchor_matched = '0;
                end else begin
                    state_next.tail_position = state_reg.tail_position + 5'd1;
                end
            end else if (hit_anchor) begin
                if (inc_idx >= ANCHOR_LEN) begin
                    state_next.anchor_matched = '0;
                    state_next.tail_active    = 1'b1;
                    state_next.tail_position  = '0;
                end else begin
                    state_next.anchor_matched = inc_idx;
                end
            end else begin
                state_next.anchor_matched = hit_first ? 4'd1 : 4'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/stream_anchor_byte_patcher_core.sv =====
// Top level of the stream anchor byte patcher: input register, step logic, result register.
//
// The block watches a byte stream for a 14-byte anchor taken from the anchor_head and
// anchor_tail registers. Once the anchor has been seen, the bytes that follow are counted as
// the tail from position zero: at tail position one a byte equal to match_value becomes
// first_replacement, at position seventeen it becomes second_replacement, and position
// seventeen always ends the tail. With enable low every byte passes unchanged and the
// tracking state holds. Each input item gives exactly one result item. The block takes one
// item per cycle while the result channel keeps taking results. An accepted item waits in
// the input register, where the compare and counter update work on it, and is written into
// the result register when that register is empty or is being drained. The stream's
// ready follows the result channel's ready only when both registers are full. Configuration
// writes are taken in any cycle and apply to items that leave the input register after the
// write.
module stream_anchor_byte_patcher_core
    import sabp_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    sabp_stream_if.sink    stream,
    sabp_result_if.source  result,
    sabp_cfg_if.sink       cfg
);

    sabp_cfg_t    cfg_q;
    sabp_state_t  state_q;
    sabp_result_t step_res;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    sabp_result_t      out_res_reg;

    logic accept;
    logic advance;

    sabp_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    sabp_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .data_byte (s1_byte_reg),
        .cfg_q     (cfg_q),
        .result    (step_res),
        .state_q   (state_q)
    );

    // The input register moves on when the result register is empty or is being drained.
    assign advance      = s1_valid_reg && (!out_valid_reg || result.ready);
    assign stream.ready = !s1_valid_reg || advance;
    assign accept       = stream.valid && stream.ready;

    assign s1_valid_next  = accept || (s1_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !result.ready);

    assign result.valid        = out_valid_reg;
    assign result.out_byte     = out_res_reg.out_byte;
    assign result.rewrote      = out_res_reg.rewrote;
    assign result.rewrite_site = out_res_reg.rewrite_site;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset; the valid flags qualify them.
    always_ff @(posedge clk)
    begin
        if (accept) begin
            s1_byte_reg <= stream.data_byte;
        end
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    // A result that was not rewritten never names the second site.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_res_reg.rewrote) |-> !out_res_reg.rewrite_site)
        else $error("rewrite_site set on a result that was not rewritten");

    // With matching off, the byte leaves unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !cfg_q.enable) |=> (out_res_reg.out_byte == $past(s1_byte_reg)))
        else $error("byte changed while matching was disabled");

    // The tail counter stays in range and rests at zero outside a tail.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_q.tail_position <= TAIL_LAST_SITE) &&
        (state_q.tail_active || state_q.tail_position == '0))
        else $error("tail position out of range");

    // The anchor count never reaches the anchor length and is zero during a tail.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_q.anchor_matched < ANCHOR_LEN) &&
        (!state_q.tail_active || state_q.anchor_matched == '0))
        else $error("anchor count inconsistent");

endmodule
